[rtl/core/assert_macros.svh]
// Assertion macros shared by the decryptor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion on the rising clock edge that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/xkfd_pkg.sv]
// Package with constants, types and helper functions of the XOR key feedback decryptor.
package xkfd_pkg;

   localparam int BYTE_W       = 8;
   localparam int KEY_BYTES    = 16;
   localparam int HIST_DEPTH   = 4;
   localparam int POS_W        = $clog2(KEY_BYTES);
   localparam int SLOT_W       = $clog2(HIST_DEPTH);
   localparam int KEY_WORD_W   = 64;
   localparam int CSR_INDEX_W  = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_CIPHER_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LOW     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_HIGH    = 2'd2;

   // Cipher mode codes.
   localparam logic MODE_PLAIN    = 1'b0;
   localparam logic MODE_FEEDBACK = 1'b1;

   typedef logic [BYTE_W-1:0]     byte_type;
   typedef logic [KEY_WORD_W-1:0] key_word_type;
   typedef logic [POS_W-1:0]      pos_type;
   typedef logic [SLOT_W-1:0]     slot_type;
   typedef byte_type              history_type [HIST_DEPTH];

   // Selects one of the sixteen key bytes; byte 0 sits in bits 7..0 of the low word.
   function automatic byte_type key_byte(key_word_type key_low, key_word_type key_high,
                                         pos_type idx);
      logic [2*KEY_WORD_W-1:0] key_all;
      key_all  = {key_high, key_low};
      key_byte = key_all[{idx, 3'b000} +: BYTE_W];
   endfunction

endpackage

[rtl/core/xkfd_if.sv]
// Valid/ready channel interfaces for the request, response and configuration words.
interface xkfd_req_if;
   logic              valid;
   logic              ready;
   xkfd_pkg::byte_type cipher_byte;
   logic              end_of_buffer;

   modport source (output valid, output cipher_byte, output end_of_buffer, input ready);
   modport sink   (input valid, input cipher_byte, input end_of_buffer, output ready);
endinterface

interface xkfd_rsp_if;
   logic              valid;
   logic              ready;
   xkfd_pkg::byte_type plain_byte;
   logic              end_out;

   modport source (output valid, output plain_byte, output end_out, input ready);
   modport sink   (input valid, input plain_byte, input end_out, output ready);
endinterface

interface xkfd_csr_if;
   logic                                valid;
   logic                                ready;
   logic [xkfd_pkg::CSR_INDEX_W-1:0]    index;
   xkfd_pkg::key_word_type              data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/xor_key_feedback_decryptor_core.sv]
// Top level of the XOR key feedback decryptor: one ciphertext word in, one plaintext word out.
//
//   Channel    Direction  Handshake          Payload
//   req_chan   in         valid / ready      cipher_byte[7:0], end_of_buffer
//   rsp_chan   out        valid / ready      plain_byte[7:0], end_out
//   csr_chan   in         valid / ready      index[1:0], data[63:0]
//
// A word is accepted in every cycle while the response register is empty or being drained,
// so the sustained rate is one word per cycle and an accepted word reaches the response
// register in the next cycle. The rate is set by the single response register, which
// is loaded straight from the key select and history XOR of the accepted word. Reset is
// synchronous and active high; it clears the mode, the key, the position and the response
// valid and marks the history as fresh. A stall on rsp_chan drops req_ready in the same
// cycle; csr_chan is always ready.
`include "assert_macros.svh"

module xor_key_feedback_decryptor_core (
   input  logic              clock,
   input  logic              reset,
   xkfd_req_if.sink          req_chan,
   xkfd_rsp_if.source        rsp_chan,
   xkfd_csr_if.sink          csr_chan
);

   // Configuration registers.
   logic                   mode_ff;
   xkfd_pkg::key_word_type key_low_ff;
   xkfd_pkg::key_word_type key_high_ff;

   // Decryption state: position within the buffer, ciphertext history and its fresh mark.
   xkfd_pkg::pos_type      pos_ff, pos_in;
   xkfd_pkg::history_type  hist_ff, hist_in;
   logic                   fresh_ff, fresh_in;

   // Response register.
   logic                   rsp_valid_ff;
   xkfd_pkg::byte_type     plain_ff, plain_in;
   logic                   end_ff;

   logic                   req_fire;
   xkfd_pkg::slot_type     slot;
   xkfd_pkg::byte_type     key_sel;
   xkfd_pkg::byte_type     hist_sel;

   // The response register can take a new word when it is empty or drains this cycle.
   assign req_chan.ready  = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire        = req_chan.valid && req_chan.ready;
   assign csr_chan.ready  = 1'b1;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.plain_byte = plain_ff;
   assign rsp_chan.end_out    = end_ff;

   // Configuration writes. An index past the list is accepted and ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= xkfd_pkg::MODE_PLAIN;
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            xkfd_pkg::CSR_CIPHER_MODE: mode_ff     <= csr_chan.data[0];
            xkfd_pkg::CSR_KEY_LOW:     key_low_ff  <= csr_chan.data;
            xkfd_pkg::CSR_KEY_HIGH:    key_high_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // The history slot follows the low two bits of the position. A fresh history reads
   // as the current key bytes 0 to 3, so it is never copied until a feedback word arrives.
   assign slot    = pos_ff[xkfd_pkg::SLOT_W-1:0];
   assign key_sel = xkfd_pkg::key_byte(key_low_ff, key_high_ff, pos_ff);

   always_comb begin
      if (fresh_ff) begin
         hist_sel = xkfd_pkg::key_byte(key_low_ff, key_high_ff,
                                       xkfd_pkg::pos_type'(slot));
      end else begin
         hist_sel = hist_ff[slot];
      end
   end

   always_comb begin
      plain_in = req_chan.cipher_byte ^ key_sel;
      if (mode_ff == xkfd_pkg::MODE_FEEDBACK) begin
         plain_in = plain_in ^ hist_sel;
      end
   end

   // Next state of the position, the history and the fresh mark for an accepted word.
   always_comb begin
      pos_in   = pos_ff;
      hist_in  = hist_ff;
      fresh_in = fresh_ff;
      if (req_fire) begin
         if (mode_ff == xkfd_pkg::MODE_FEEDBACK) begin
            // Load the whole history from the key before the ciphertext goes into its slot.
            if (fresh_ff) begin
               for (int i = 0; i < xkfd_pkg::HIST_DEPTH; i++) begin
                  hist_in[i] = xkfd_pkg::key_byte(key_low_ff, key_high_ff,
                                                  xkfd_pkg::pos_type'(i));
               end
            end
            hist_in[slot] = req_chan.cipher_byte;
            fresh_in      = 1'b0;
         end
         if (req_chan.end_of_buffer) begin
            // The last word of a buffer restarts the position and the history.
            pos_in   = '0;
            fresh_in = 1'b1;
         end else begin
            pos_in   = pos_ff + xkfd_pkg::pos_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         fresh_ff <= 1'b1;
      end else begin
         pos_ff   <= pos_in;
         fresh_ff <= fresh_in;
      end
   end

   // The history is payload: the fresh mark covers its contents after reset.
   always_ff @(posedge clock) begin
      hist_ff <= hist_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         plain_ff <= plain_in;
         end_ff   <= req_chan.end_of_buffer;
      end
   end

   // A last word always leaves the position at zero and the history fresh.
   `ASSERT_CLK(a_end_restarts, clock, reset, req_fire && req_chan.end_of_buffer |=> pos_ff == '0 && fresh_ff, "end of buffer did not restart the state")
   // Every accepted word shows up in the response register in the next cycle.
   `ASSERT_CLK(a_fire_to_rsp, clock, reset, req_fire |=> rsp_valid_ff, "accepted word missing from response register")
   // A plain mode word in mid-buffer leaves the fresh mark alone.
   `ASSERT_CLK(a_plain_keeps_fresh, clock, reset, req_fire && mode_ff == xkfd_pkg::MODE_PLAIN && !req_chan.end_of_buffer |=> $stable(fresh_ff), "plain mode word changed the history mark")
   // A held response blocks new words so that none is overwritten.
   `ASSERT_ALWAYS(a_stall_blocks, clock, rsp_valid_ff && !rsp_chan.ready |-> !req_chan.ready, "request accepted over a held response")

endmodule
